/* sv/tct_pkg.sv */
`timescale 1ns / 1ps
// Types, codes and constants shared by the category code tokenizer.
package tct_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int LINE_BITS     = 24;
  localparam int CODE_W        = 21;
  localparam int CAT_W         = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] FUNC_CHAR  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [CAT_W-1:0] CAT_ESCAPE  = 4'd0;
  localparam logic [CAT_W-1:0] CAT_BGROUP  = 4'd1;
  localparam logic [CAT_W-1:0] CAT_EGROUP  = 4'd2;
  localparam logic [CAT_W-1:0] CAT_MATH    = 4'd3;
  localparam logic [CAT_W-1:0] CAT_ALIGN   = 4'd4;
  localparam logic [CAT_W-1:0] CAT_NEWLINE = 4'd5;
  localparam logic [CAT_W-1:0] CAT_PARAM   = 4'd6;
  localparam logic [CAT_W-1:0] CAT_SUPER   = 4'd7;
  localparam logic [CAT_W-1:0] CAT_SUB     = 4'd8;
  localparam logic [CAT_W-1:0] CAT_IGNORE  = 4'd9;
  localparam logic [CAT_W-1:0] CAT_SPACE   = 4'd10;
  localparam logic [CAT_W-1:0] CAT_LETTER  = 4'd11;
  localparam logic [CAT_W-1:0] CAT_OTHER   = 4'd12;
  localparam logic [CAT_W-1:0] CAT_ACTIVE  = 4'd13;
  localparam logic [CAT_W-1:0] CAT_COMMENT = 4'd14;

  localparam logic [CODE_W-1:0] CHAR_LF = 21'd10;
  localparam logic [CODE_W-1:0] CHAR_CR = 21'd13;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_SPACE       = 3'd1,
    MODE_NEWLINE     = 3'd2,
    MODE_COMMENT     = 3'd3,
    MODE_ESC_WAIT    = 3'd4,
    MODE_ESC_LETTERS = 3'd5
  } mode_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [CODE_W-1:0] code;
    logic [CAT_W-1:0]  cat;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CAT_W-1:0]  cat;
    logic [CODE_W-1:0] ch;
    logic              err;
    logic              after;
  } result_t;

  function automatic logic [CAT_W-1:0] default_cat(input logic [7:0] c);
    logic [CAT_W-1:0] r;
    r = CAT_OTHER;
    case (c)
      8'h5C: r = CAT_ESCAPE;
      8'h7B: r = CAT_BGROUP;
      8'h7D: r = CAT_EGROUP;
      8'h24: r = CAT_MATH;
      8'h26: r = CAT_ALIGN;
      8'h0A: r = CAT_NEWLINE;
      8'h0D: r = CAT_NEWLINE;
      8'h23: r = CAT_PARAM;
      8'h5E: r = CAT_SUPER;
      8'h5F: r = CAT_SUB;
      8'h7F: r = CAT_IGNORE;
      8'h20: r = CAT_SPACE;
      8'h09: r = CAT_SPACE;
      8'h7E: r = CAT_ACTIVE;
      8'h25: r = CAT_COMMENT;
      8'h40: r = CAT_LETTER;
      default: begin
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
          r = CAT_LETTER;
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* sv/tct_front.sv */
`timescale 1ns / 1ps
// Front end: accepts transactions, keeps the category table and classifies characters.
module tct_front
  import tct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  output logic              push,
  output item_t             push_item,
  input  logic              full
);

  logic [CAT_W-1:0]         cat_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cat_vld;

  logic                     accept;
  logic [CODE_W-1:0]        in_code;
  logic [CAT_W-1:0]         in_cat;
  logic [TABLE_AW-1:0]      addr;
  logic                     in_range;
  logic                     advance;

  logic                     s1_valid;
  logic [1:0]               s1_func;
  logic [CODE_W-1:0]        s1_code;
  logic                     s1_in_range;
  logic [CAT_W-1:0]         rd_cat;
  logic                     rd_vld;
  logic [CAT_W-1:0]         rd_dflt;

  assign in_code  = s_axis_tdata[CODE_W-1:0];
  assign in_cat   = s_axis_tdata[CODE_W+CAT_W-1:CODE_W];
  assign addr     = in_code[TABLE_AW-1:0];
  assign in_range = in_code < CODE_W'(TABLE_ENTRIES);

  assign advance       = !s1_valid || !full;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == FUNC_WRITE && in_range) begin
      cat_mem[addr] <= in_cat;
    end
    if (accept) begin
      rd_cat  <= cat_mem[addr];
      rd_dflt <= default_cat(8'(addr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cat_vld  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept && s_axis_tuser == FUNC_WRITE && in_range) begin
        cat_vld[addr] <= 1'b1;
      end
      if (advance) begin
        s1_valid <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func     <= s_axis_tuser;
      s1_code     <= in_code;
      s1_in_range <= in_range;
      rd_vld      <= cat_vld[addr];
    end
  end

  assign push           = s1_valid && !full;
  assign push_item.func = s1_func;
  assign push_item.code = s1_code;
  assign push_item.cat  = !s1_in_range ? CAT_OTHER : (rd_vld ? rd_cat : rd_dflt);

endmodule

/* sv/tct_fifo.sv */
`timescale 1ns / 1ps
// Short queue of classified items between the front and back ends.
module tct_fifo
  import tct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  head_valid,
  output item_t head_item,
  input  logic  pop
);

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/tct_back.sv */
`timescale 1ns / 1ps
// Back end: lexer state, token grouping and the output register.
module tct_back
  import tct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // category, char_out, line_number, input_error
  output logic [1:0]  m_axis_tuser    // kind
);

  mode_t                 mode;
  mode_t                 mode_next;
  logic                  swallow;
  logic                  swallow_next;
  logic [LINE_BITS-1:0]  line_count;
  logic [LINE_BITS-1:0]  line_inc;
  logic                  inc;

  logic                  is_char;
  logic                  drop;
  logic                  is_cr;
  logic [CODE_W-1:0]     norm;
  logic                  start_tok;
  logic                  close_tok;
  logic [CAT_W-1:0]      cur_cat;

  result_t               res [4];
  logic [2:0]            n_res;
  logic [1:0]            idx;
  logic                  load_ok;
  logic                  last;

  logic [1:0]            out_kind;
  logic [CAT_W-1:0]      out_cat;
  logic [CODE_W-1:0]     out_ch;
  logic [LINE_BITS-1:0]  out_line;
  logic                  out_err;

  function automatic result_t mk(input logic [1:0] kind, input logic [CAT_W-1:0] cat,
                                 input logic [CODE_W-1:0] ch, input logic err,
                                 input logic after);
    result_t r;
    r.kind  = kind;
    r.cat   = cat;
    r.ch    = ch;
    r.err   = err;
    r.after = after;
    return r;
  endfunction

  function automatic logic [CAT_W-1:0] mode_cat(input mode_t m);
    logic [CAT_W-1:0] r;
    case (m)
      MODE_SPACE:   r = CAT_SPACE;
      MODE_NEWLINE: r = CAT_NEWLINE;
      MODE_COMMENT: r = CAT_COMMENT;
      default:      r = CAT_ESCAPE;
    endcase
    return r;
  endfunction

  assign cur_cat  = head_item.cat;
  assign is_char  = head_item.func == FUNC_CHAR;
  assign drop     = swallow && head_item.code == CHAR_LF;
  assign is_cr    = head_item.code == CHAR_CR;
  assign norm     = is_cr ? CHAR_LF : head_item.code;
  assign line_inc = (line_count == '1) ? line_count : line_count + 1'b1;

  always_comb begin
    start_tok = 1'b0;
    if (is_char && !drop) begin
      case (mode)
        MODE_SPACE:       start_tok = cur_cat != CAT_SPACE;
        MODE_NEWLINE:     start_tok = cur_cat != CAT_NEWLINE;
        MODE_COMMENT:     start_tok = 1'b0;
        MODE_ESC_WAIT:    start_tok = 1'b0;
        MODE_ESC_LETTERS: start_tok = cur_cat != CAT_LETTER;
        default:          start_tok = 1'b1;
      endcase
    end
  end

  assign close_tok = start_tok &&
                     (mode == MODE_SPACE || mode == MODE_NEWLINE || mode == MODE_ESC_LETTERS);

  // next state
  always_comb begin
    mode_next    = mode;
    swallow_next = swallow;
    inc          = 1'b0;
    case (head_item.func)
      FUNC_CHAR: begin
        swallow_next = 1'b0;
        if (!drop) begin
          case (mode)
            MODE_NEWLINE: begin
              if (cur_cat == CAT_NEWLINE) begin
                inc          = 1'b1;
                swallow_next = is_cr;
              end
            end
            MODE_COMMENT: begin
              if (cur_cat == CAT_NEWLINE) begin
                inc          = 1'b1;
                mode_next    = MODE_IDLE;
                swallow_next = is_cr;
              end
            end
            MODE_ESC_WAIT: begin
              mode_next = (cur_cat == CAT_LETTER) ? MODE_ESC_LETTERS : MODE_IDLE;
            end
            default: begin
            end
          endcase
          if (start_tok) begin
            mode_next = MODE_IDLE;
            case (cur_cat)
              CAT_SPACE:   mode_next = MODE_SPACE;
              CAT_NEWLINE: begin
                inc          = 1'b1;
                swallow_next = is_cr;
                mode_next    = MODE_NEWLINE;
              end
              CAT_COMMENT: mode_next = MODE_COMMENT;
              CAT_ESCAPE:  mode_next = MODE_ESC_WAIT;
              default:     mode_next = MODE_IDLE;
            endcase
          end
        end
      end
      FUNC_END: begin
        mode_next    = MODE_IDLE;
        swallow_next = 1'b0;
        inc          = mode == MODE_COMMENT;
      end
      default: begin
      end
    endcase
  end

  // results of the head item
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = '0;
    end
    n_res = 3'd0;
    case (head_item.func)
      FUNC_CHAR: begin
        if (!drop) begin
          case (mode)
            MODE_SPACE: begin
              if (cur_cat == CAT_SPACE) begin
                res[n_res[1:0]] = mk(KIND_CHAR, CAT_SPACE, head_item.code, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
              end
            end
            MODE_NEWLINE: begin
              if (cur_cat == CAT_NEWLINE) begin
                res[n_res[1:0]] = mk(KIND_CHAR, CAT_NEWLINE, norm, 1'b0, 1'b1);
                n_res = n_res + 3'd1;
              end
            end
            MODE_COMMENT: begin
              if (cur_cat == CAT_NEWLINE) begin
                res[n_res[1:0]] = mk(KIND_END, CAT_COMMENT, '0, 1'b0, 1'b1);
              end else begin
                res[n_res[1:0]] = mk(KIND_CHAR, CAT_COMMENT, head_item.code, 1'b0, 1'b0);
              end
              n_res = n_res + 3'd1;
            end
            MODE_ESC_WAIT: begin
              res[n_res[1:0]] = mk(KIND_CHAR, CAT_ESCAPE, head_item.code, 1'b0, 1'b0);
              n_res = n_res + 3'd1;
              if (cur_cat != CAT_LETTER) begin
                res[n_res[1:0]] = mk(KIND_END, CAT_ESCAPE, '0, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
              end
            end
            MODE_ESC_LETTERS: begin
              if (cur_cat == CAT_LETTER) begin
                res[n_res[1:0]] = mk(KIND_CHAR, CAT_ESCAPE, head_item.code, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
              end
            end
            default: begin
            end
          endcase
          if (close_tok) begin
            res[n_res[1:0]] = mk(KIND_END, mode_cat(mode), '0, 1'b0, 1'b0);
            n_res = n_res + 3'd1;
          end
          if (start_tok) begin
            case (cur_cat)
              CAT_IGNORE: begin
              end
              CAT_SPACE: begin
                res[n_res[1:0]] = mk(KIND_START, cur_cat, '0, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
                res[n_res[1:0]] = mk(KIND_CHAR, cur_cat, head_item.code, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
              end
              CAT_NEWLINE: begin
                res[n_res[1:0]] = mk(KIND_START, cur_cat, '0, 1'b0, 1'b1);
                n_res = n_res + 3'd1;
                res[n_res[1:0]] = mk(KIND_CHAR, cur_cat, norm, 1'b0, 1'b1);
                n_res = n_res + 3'd1;
              end
              CAT_COMMENT, CAT_ESCAPE: begin
                res[n_res[1:0]] = mk(KIND_START, cur_cat, '0, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
              end
              default: begin
                res[n_res[1:0]] = mk(KIND_START, cur_cat, '0, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
                res[n_res[1:0]] = mk(KIND_CHAR, cur_cat, head_item.code, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
                res[n_res[1:0]] = mk(KIND_END, cur_cat, '0, 1'b0, 1'b0);
                n_res = n_res + 3'd1;
              end
            endcase
          end
        end
      end
      FUNC_END: begin
        case (mode)
          MODE_SPACE, MODE_NEWLINE, MODE_ESC_LETTERS: begin
            res[0] = mk(KIND_END, mode_cat(mode), '0, 1'b0, 1'b0);
            n_res  = 3'd1;
          end
          MODE_COMMENT: begin
            res[0] = mk(KIND_END, CAT_COMMENT, '0, 1'b0, 1'b1);
            n_res  = 3'd1;
          end
          MODE_ESC_WAIT: begin
            res[0] = mk(KIND_END, CAT_ESCAPE, '0, 1'b1, 1'b0);
            n_res  = 3'd1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign load_ok = !m_axis_tvalid || m_axis_tready;
  assign last    = (3'(idx) + 3'd1) == n_res;
  assign pop     = head_valid && (n_res == 3'd0 || (load_ok && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      swallow       <= 1'b0;
      line_count    <= '0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        mode    <= mode_next;
        swallow <= swallow_next;
        if (inc) begin
          line_count <= line_inc;
        end
      end
      if (head_valid && n_res != 3'd0 && load_ok) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
      if (load_ok) begin
        m_axis_tvalid <= head_valid && n_res != 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid && n_res != 3'd0 && load_ok) begin
      out_kind <= res[idx].kind;
      out_cat  <= res[idx].cat;
      out_ch   <= res[idx].ch;
      out_err  <= res[idx].err;
      out_line <= res[idx].after ? line_inc : line_count;
    end
  end

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {6'd0, out_err, out_line, out_ch, out_cat};

endmodule

/* sv/tex_catcode_tokenizer.sv */
`timescale 1ns / 1ps
// Top level of the category code tokenizer.
// One transaction in carries a character, a category table write or an end of input.
// Input transactions are taken at one per clock unless the queue and the classify
// stage are both full; each is classified through the 256-entry category table
// (registered read) and queued for the lexer. The lexer sends one result per clock
// while the receiver is ready; an item yields at most four results, and one with none
// leaves the queue without output. The table comes out of reset with the default
// assignments at once, with no clearing pass; a table write affects later characters.
module tex_catcode_tokenizer
  import tct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // code, new_category
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // category, char_out, line_number, input_error
  output logic [1:0]  m_axis_tuser    // kind
);

  logic  push;
  item_t push_item;
  logic  full;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  tct_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .push_item     (push_item),
    .full          (full)
  );

  tct_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  tct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* sv/tct_checker.sv */
`timescale 1ns / 1ps
// Port checker for the tokenizer, bound to the top level.
module tct_checker
  import tct_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic                 out_acc;
  logic [LINE_BITS-1:0] last_line;
  logic [LINE_BITS-1:0] cur_line;

  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign cur_line = m_axis_tdata[LINE_BITS+24:25];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_line <= '0;
    end else if (out_acc) begin
      last_line <= cur_line;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown straight after reset");

  a_line_order: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> cur_line >= last_line)
    else $error("line number went backwards");

  a_error_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[49] |->
      m_axis_tuser == KIND_END && m_axis_tdata[3:0] == CAT_ESCAPE)
    else $error("input error outside an escape end");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_CHAR |-> m_axis_tdata[24:4] == '0)
    else $error("character field set on a start or end result");

endmodule

bind tex_catcode_tokenizer tct_checker u_tct_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the category code tokenizer: table-driven directed items,
// then random text, checked against a behavioural lexer model or fixed expected results.
module tb_top;
  import tct_pkg::*;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CAT_W-1:0]     cat;
    logic [CODE_W-1:0]    ch;
    logic [LINE_BITS-1:0] line;
    logic                 err;
  } tok_res_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [CODE_W-1:0] code;
    logic [CAT_W-1:0]  ncat;
    logic              typed;
    logic [2:0]        n_typed;
  } stim_row_t;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int DIR_ROWS     = 28;
  localparam int TYPED_RES    = 5;
  localparam int RANDOM_ITEMS = 340;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [CODE_W-1:0] CHAR_SP  = 21'h20;
  localparam logic [CODE_W-1:0] CHAR_TAB = 21'h09;
  localparam logic [CODE_W-1:0] CHAR_BS  = 21'h5C;
  localparam logic [CODE_W-1:0] CHAR_PCT = 21'h25;
  localparam logic [CODE_W-1:0] CODE_MAX = 21'h1FFFFF;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  tex_catcode_tokenizer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  stim_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{FUNC_CHAR,  CHAR_BS,  4'd0,        1'b1, 3'd1},
    '{FUNC_END,   21'd0,    4'd0,        1'b1, 3'd1},
    '{FUNC_CHAR,  CODE_MAX, 4'd0,        1'b1, 3'd3},
    '{FUNC_CHAR,  21'h7F,   4'd0,        1'b1, 3'd0},
    '{FUNC_WRITE, 21'h100,  4'hF,        1'b1, 3'd0},
    '{FUNC_NONE,  CODE_MAX, 4'hF,        1'b1, 3'd0},
    '{FUNC_CHAR,  CHAR_SP,  4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_TAB, 4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_CR,  4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_LF,  4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_LF,  4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_PCT, 4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  21'h78,   4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_CR,  4'd0,        1'b0, 3'd0},
    '{FUNC_WRITE, CHAR_LF,  CAT_OTHER,   1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_LF,  4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_LF,  4'd0,        1'b0, 3'd0},
    '{FUNC_WRITE, CHAR_LF,  CAT_NEWLINE, 1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_BS,  4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  21'h61,   4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  21'h40,   4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  21'h7B,   4'd0,        1'b0, 3'd0},
    '{FUNC_WRITE, 21'h41,   4'hF,        1'b0, 3'd0},
    '{FUNC_CHAR,  21'h41,   4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_BS,  4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  21'd0,    4'd0,        1'b0, 3'd0},
    '{FUNC_CHAR,  CHAR_PCT, 4'd0,        1'b0, 3'd0},
    '{FUNC_END,   21'd0,    4'd0,        1'b0, 3'd0}
  };

  tok_res_t typed_res [0:TYPED_RES-1] = '{
    '{KIND_START, CAT_ESCAPE, 21'd0,    24'd0, 1'b0},
    '{KIND_END,   CAT_ESCAPE, 21'd0,    24'd0, 1'b1},
    '{KIND_START, CAT_OTHER,  21'd0,    24'd0, 1'b0},
    '{KIND_CHAR,  CAT_OTHER,  CODE_MAX, 24'd0, 1'b0},
    '{KIND_END,   CAT_OTHER,  21'd0,    24'd0, 1'b0}
  };

  logic [7:0] punct [0:11] = '{8'h7B, 8'h7D, 8'h24, 8'h26, 8'h23, 8'h5E,
                               8'h5F, 8'h7E, 8'h40, 8'h30, 8'h2E, 8'h7F};

  // lexer model state
  logic [CAT_W-1:0]     cat_tab [0:255];
  mode_t                lex_mode;
  logic                 swallow_lf;
  logic [LINE_BITS-1:0] lines;
  tok_res_t             fresh [$];
  tok_res_t             awaited [$];
  int                   touched [$];

  int errors;
  int burst_left;
  int idle_cycles;
  int sent;

  function automatic logic [CAT_W-1:0] tex_default(input int idx);
    if ((idx >= 8'h61 && idx <= 8'h7A) || (idx >= 8'h41 && idx <= 8'h5A) || idx == 8'h40)
      return CAT_LETTER;
    case (idx)
      8'h5C: return CAT_ESCAPE;
      8'h7B: return CAT_BGROUP;
      8'h7D: return CAT_EGROUP;
      8'h24: return CAT_MATH;
      8'h26: return CAT_ALIGN;
      8'h0A, 8'h0D: return CAT_NEWLINE;
      8'h23: return CAT_PARAM;
      8'h5E: return CAT_SUPER;
      8'h5F: return CAT_SUB;
      8'h7F: return CAT_IGNORE;
      8'h20, 8'h09: return CAT_SPACE;
      8'h7E: return CAT_ACTIVE;
      8'h25: return CAT_COMMENT;
      default: return CAT_OTHER;
    endcase
  endfunction

  task automatic lex_reset();
    for (int i = 0; i < 256; i++) cat_tab[i] = tex_default(i);
    lex_mode = MODE_IDLE;
    swallow_lf = 1'b0;
    lines = '0;
  endtask

  task automatic put(input logic [1:0] kind, input logic [CAT_W-1:0] cat,
                     input logic [CODE_W-1:0] ch, input logic err);
    tok_res_t r;
    r = '{kind, cat, ch, lines, err};
    fresh = {fresh, r};
  endtask

  task automatic bump_line();
    if (lines != '1) lines = lines + 1'b1;
  endtask

  function automatic logic [CAT_W-1:0] open_cat();
    case (lex_mode)
      MODE_SPACE:   return CAT_SPACE;
      MODE_NEWLINE: return CAT_NEWLINE;
      MODE_COMMENT: return CAT_COMMENT;
      default:      return CAT_ESCAPE;
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] norm_eol(input logic [CODE_W-1:0] c);
    return (c == CHAR_CR) ? CHAR_LF : c;
  endfunction

  task automatic open_token(input logic [CODE_W-1:0] c, input logic [CAT_W-1:0] k);
    case (k)
      CAT_IGNORE: ;
      CAT_SPACE: begin
        put(KIND_START, k, '0, 1'b0);
        put(KIND_CHAR, k, c, 1'b0);
        lex_mode = MODE_SPACE;
      end
      CAT_NEWLINE: begin
        bump_line();
        put(KIND_START, k, '0, 1'b0);
        put(KIND_CHAR, k, norm_eol(c), 1'b0);
        if (c == CHAR_CR) swallow_lf = 1'b1;
        lex_mode = MODE_NEWLINE;
      end
      CAT_COMMENT: begin
        put(KIND_START, k, '0, 1'b0);
        lex_mode = MODE_COMMENT;
      end
      CAT_ESCAPE: begin
        put(KIND_START, k, '0, 1'b0);
        lex_mode = MODE_ESC_WAIT;
      end
      default: begin
        put(KIND_START, k, '0, 1'b0);
        put(KIND_CHAR, k, c, 1'b0);
        put(KIND_END, k, '0, 1'b0);
      end
    endcase
  endtask

  task automatic close_then_open(input logic [CODE_W-1:0] c, input logic [CAT_W-1:0] k);
    put(KIND_END, open_cat(), '0, 1'b0);
    lex_mode = MODE_IDLE;
    open_token(c, k);
  endtask

  task automatic lex_char(input logic [CODE_W-1:0] c);
    logic [CAT_W-1:0] k;
    if (swallow_lf) begin
      swallow_lf = 1'b0;
      if (c == CHAR_LF) return;
    end
    k = (c < TABLE_ENTRIES) ? cat_tab[c[7:0]] : CAT_OTHER;
    case (lex_mode)
      MODE_SPACE: begin
        if (k == CAT_SPACE) put(KIND_CHAR, CAT_SPACE, c, 1'b0);
        else close_then_open(c, k);
      end
      MODE_NEWLINE: begin
        if (k == CAT_NEWLINE) begin
          bump_line();
          put(KIND_CHAR, CAT_NEWLINE, norm_eol(c), 1'b0);
          if (c == CHAR_CR) swallow_lf = 1'b1;
        end else begin
          close_then_open(c, k);
        end
      end
      MODE_COMMENT: begin
        if (k == CAT_NEWLINE) begin
          bump_line();
          put(KIND_END, CAT_COMMENT, '0, 1'b0);
          lex_mode = MODE_IDLE;
          if (c == CHAR_CR) swallow_lf = 1'b1;
        end else begin
          put(KIND_CHAR, CAT_COMMENT, c, 1'b0);
        end
      end
      MODE_ESC_WAIT: begin
        put(KIND_CHAR, CAT_ESCAPE, c, 1'b0);
        if (k == CAT_LETTER) begin
          lex_mode = MODE_ESC_LETTERS;
        end else begin
          put(KIND_END, CAT_ESCAPE, '0, 1'b0);
          lex_mode = MODE_IDLE;
        end
      end
      MODE_ESC_LETTERS: begin
        if (k == CAT_LETTER) put(KIND_CHAR, CAT_ESCAPE, c, 1'b0);
        else close_then_open(c, k);
      end
      default: begin
        lex_mode = MODE_IDLE;
        open_token(c, k);
      end
    endcase
  endtask

  task automatic lex_end();
    case (lex_mode)
      MODE_SPACE, MODE_NEWLINE, MODE_ESC_LETTERS: put(KIND_END, open_cat(), '0, 1'b0);
      MODE_COMMENT: begin
        bump_line();
        put(KIND_END, CAT_COMMENT, '0, 1'b0);
      end
      MODE_ESC_WAIT: put(KIND_END, CAT_ESCAPE, '0, 1'b1);
      default: ;
    endcase
    lex_mode = MODE_IDLE;
    swallow_lf = 1'b0;
  endtask

  task automatic lex_predict(input logic [1:0] f, input logic [CODE_W-1:0] c,
                             input logic [CAT_W-1:0] nc);
    fresh.delete();
    case (f)
      FUNC_CHAR: lex_char(c);
      FUNC_WRITE: begin
        if (c < TABLE_ENTRIES) begin
          cat_tab[c[7:0]] = nc;
          touched = {touched, int'(c)};
        end
      end
      FUNC_END: lex_end();
      default: ;
    endcase
  endtask

  // hold the item until accepted; gaps fall between bursts
  task automatic send(input logic [1:0] f, input logic [CODE_W-1:0] c,
                      input logic [CAT_W-1:0] nc, input bit predicted);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, nc, c};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    sent++;
    lex_predict(f, c, nc);
    if (predicted) awaited = {awaited, fresh};
  endtask

  task automatic send_char(input logic [CODE_W-1:0] c);
    send(FUNC_CHAR, c, 4'($urandom_range(0, 15)), 1'b1);
  endtask

  function automatic logic [CODE_W-1:0] any_letter();
    return 21'($urandom_range(0, 1) ? 32'h41 + $urandom_range(0, 25)
                                    : 32'h61 + $urandom_range(0, 25));
  endfunction

  task automatic send_eol();
    case ($urandom_range(0, 2))
      0: send_char(CHAR_LF);
      1: send_char(CHAR_CR);
      default: begin
        send_char(CHAR_CR);
        send_char(CHAR_LF);
      end
    endcase
  endtask

  task automatic send_wild();
    if ($urandom_range(0, 1)) send_char(21'($urandom_range(0, 32'h1FFFFF)));
    else send_char(21'($urandom_range(0, 255)));
  endtask

  task automatic restore_table();
    int idx [$];
    idx = touched;
    touched.delete();
    foreach (idx[i]) send(FUNC_WRITE, 21'(idx[i]), tex_default(idx[i]), 1'b1);
    touched.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_text_piece();
    int n;
    int r;
    logic [CODE_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      n = $urandom_range(1, 6);
      repeat (n) send_char(any_letter());
    end else if (r < 40) begin
      send_char(CHAR_BS);
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, 5);
        repeat (n) send_char(any_letter());
      end else begin
        case ($urandom_range(0, 3))
          0: send_char(21'(punct[$urandom_range(0, 11)]));
          1: send_char($urandom_range(0, 1) ? CHAR_SP : CHAR_CR);
          2: send_char(CHAR_BS);
          default: send_wild();
        endcase
      end
    end else if (r < 52) begin
      n = $urandom_range(1, 4);
      repeat (n) send_char($urandom_range(0, 2) ? CHAR_SP : CHAR_TAB);
    end else if (r < 64) begin
      n = $urandom_range(1, 3);
      repeat (n) send_eol();
    end else if (r < 72) begin
      send_char(CHAR_PCT);
      n = $urandom_range(0, 5);
      repeat (n) begin
        c = $urandom_range(0, 7) ? 21'($urandom_range(8'h21, 8'h7E))
                                 : 21'($urandom_range(0, 32'h1FFFFF));
        send_char(c);
      end
      if ($urandom_range(0, 4)) send_eol();
    end else if (r < 84) begin
      send_char(21'(punct[$urandom_range(0, 11)]));
    end else if (r < 90) begin
      send_wild();
    end else if (r < 94) begin
      case ($urandom_range(0, 9))
        0: c = 21'($urandom_range(0, 32'h1FFFFF));
        1, 2: c = 21'($urandom_range(128, 255));
        default: c = 21'($urandom_range(0, 127));
      endcase
      send(FUNC_WRITE, c, 4'($urandom_range(0, 15)), 1'b1);
    end else if (r < 97) begin
      send(FUNC_END, 21'($urandom_range(0, 32'h1FFFFF)), 4'($urandom_range(0, 15)), 1'b1);
    end else if (r < 98) begin
      send(FUNC_NONE, 21'($urandom_range(0, 32'h1FFFFF)), 4'($urandom_range(0, 15)), 1'b1);
    end else begin
      restore_table();
    end
  endtask

  // receiver: switch between stall patterns every so often
  int rx_mode;
  int rx_left;
  int rx_tick;
  always @(negedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_tick % 4) != 3;
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    tok_res_t got;
    tok_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[24:4], m_axis_tdata[48:25],
              m_axis_tdata[49]};
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result kind=%0d cat=%0d ch=%h line=%0d err=%0d",
                 $time, got.kind, got.cat, got.ch, got.line, got.err);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected kind=%0d cat=%0d ch=%h line=%0d err=%0d",
                   $time, want.kind, want.cat, want.ch, want.line, want.err);
          $display("%0t:          actual   kind=%0d cat=%0d ch=%h line=%0d err=%0d",
                   $time, got.kind, got.cat, got.ch, got.line, got.err);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int typed_pos;
    bit paused;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    burst_left    = 0;
    sent          = 0;
    typed_pos     = 0;
    paused        = 1'b0;
    lex_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send(dir_rows[i].func, dir_rows[i].code, dir_rows[i].ncat, !dir_rows[i].typed);
      if (dir_rows[i].typed) begin
        repeat (dir_rows[i].n_typed) begin
          awaited = {awaited, typed_res[typed_pos]};
          typed_pos++;
        end
      end
    end
    restore_table();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_text_piece();
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    send(FUNC_END, '0, '0, 1'b1);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
sv/tct_pkg.sv
sv/tct_front.sv
sv/tct_fifo.sv
sv/tct_back.sv
sv/tex_catcode_tokenizer.sv
sv/tct_checker.sv
tb/tb_top.sv
